FILE: hdl/nmcs_pkg.sv
// Shared constants, register indexes and controller/datapath interface types.
package nmcs_pkg;

   // Default layer size held in the cell map
   localparam int MaxWidthDefault  = 64;
   localparam int MaxHeightDefault = 64;

   // Field widths
   localparam int PosWidth     = 6;
   localparam int CfgWidth     = 7;
   localparam int CsrAddrWidth = 1;

   // Ring walk arithmetic: coordinates may fall outside the layer on either side
   localparam int CoordWidth = 9;
   localparam int RadWidth   = 8;
   localparam int DistWidth  = 9;

   // Grid size after reset
   localparam logic [CfgWidth-1:0] GridSizeReset = 7'd64;

   // Configuration register indexes
   localparam logic [CsrAddrWidth-1:0] CsrGridWidth  = 1'b0;
   localparam logic [CsrAddrWidth-1:0] CsrGridHeight = 1'b1;

   // Request command codes
   localparam logic CmdWrite  = 1'b0;
   localparam logic CmdSearch = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;         // capture request fields, set up ring limit
      logic clear_step;   // clear one map entry after reset
      logic write_cell;   // store the captured mark
      logic ring_start;   // put the cursor on the first cell of the ring
      logic step;         // probe the cursor cell and advance
      logic next_ring;    // grow the radius by one
      logic claim;        // clear the best cell and report it
      logic respond_none; // report an empty result
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic no_rings;
      logic ring_last;
      logic last_ring;
      logic have;
   } ctrl_status_type;

endpackage

FILE: hdl/nearest_marked_cell_search_unit.sv
// Top level: nearest marked cell search unit with claim.
//
// After reset the unit clears its cell map one entry per cycle, covering all
// MAX_WIDTH*MAX_HEIGHT entries (4096 with the defaults); busy is high meanwhile,
// and configuration writes are taken at any time. A write transaction stores
// its mark and then registers its result strobe. A search walks square rings
// around the origin through one map read port, one cell per cycle; each ring
// is started, walked, drained and checked, and the search ends after the first
// ring holding a marked cell or after the ring that reaches the farthest grid
// edge. Each result is presented for one cycle on rsp_valid and cannot be
// stalled; a new transaction may be started in the cycle its predecessor's
// result is shown.
module nearest_marked_cell_search_unit import nmcs_pkg::*; #(
   parameter int MAX_WIDTH  = MaxWidthDefault,
   parameter int MAX_HEIGHT = MaxHeightDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_cmd,
   input  logic [PosWidth-1:0]     req_pos_x,
   input  logic [PosWidth-1:0]     req_pos_y,
   input  logic                    req_cell_marked,
   output logic                    rsp_valid,
   output logic                    rsp_found,
   output logic [PosWidth-1:0]     rsp_near_x,
   output logic [PosWidth-1:0]     rsp_near_y,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CfgWidth-1:0]     csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   nmcs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_cmd(req_cmd),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   nmcs_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_cell_marked(req_cell_marked),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_near_x     (rsp_near_x),
      .rsp_near_y     (rsp_near_y),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata)
   );

endmodule

FILE: hdl/nmcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nmcs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096,
   localparam int AddrWidth = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: hdl/nmcs_datapath.sv
// Datapath: config registers, cell map, ring cursor, probe pipeline and best-cell tracking.
module nmcs_datapath import nmcs_pkg::*; #(
   parameter int MAX_WIDTH  = MaxWidthDefault,
   parameter int MAX_HEIGHT = MaxHeightDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output ctrl_status_type         status,
   input  logic [PosWidth-1:0]     req_pos_x,
   input  logic [PosWidth-1:0]     req_pos_y,
   input  logic                    req_cell_marked,
   output logic                    rsp_valid,
   output logic                    rsp_found,
   output logic [PosWidth-1:0]     rsp_near_x,
   output logic [PosWidth-1:0]     rsp_near_y,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CfgWidth-1:0]     csr_wdata
);

   localparam int Depth     = MAX_WIDTH * MAX_HEIGHT;
   localparam int AddrWidth = $clog2(Depth);
   localparam int ProdWidth = 2 * CoordWidth;
   localparam int ExtWidth  = CoordWidth - PosWidth;
   localparam logic [CoordWidth-1:0] MaxW = CoordWidth'(MAX_WIDTH);
   localparam logic [CoordWidth-1:0] MaxH = CoordWidth'(MAX_HEIGHT);
   localparam logic [AddrWidth-1:0]  LastAddr = AddrWidth'(Depth - 1);

   // Configuration registers
   logic [CfgWidth-1:0] grid_w_ff, grid_h_ff;

   // Request capture and ring state
   logic [PosWidth-1:0]  ox_ff, oy_ff;
   logic                 mark_ff;
   logic [RadWidth-1:0]  lim_ff, r_ff;
   logic [AddrWidth-1:0] clr_ff;

   // Ring cursor: phase 0 walks the rows, phase 1 the columns
   logic                         phase_ff;
   logic                         side_ff;
   logic signed [CoordWidth-1:0] off_ff;

   // Probe pipeline (one cell in flight behind the RAM read)
   logic                 probe_vld_ff;
   logic [PosWidth-1:0]  probe_x_ff, probe_y_ff;
   logic [DistWidth-1:0] probe_d_ff;
   logic [AddrWidth-1:0] probe_addr_ff;
   logic [0:0]           rd_data;

   // Best cell of the current ring
   logic                 have_ff;
   logic [PosWidth-1:0]  best_x_ff, best_y_ff;
   logic [DistWidth-1:0] best_d_ff;
   logic [AddrWidth-1:0] best_addr_ff;

   // Response registers
   logic                rsp_valid_ff, rsp_found_ff;
   logic [PosWidth-1:0] rsp_x_ff, rsp_y_ff;

   // Combinational nets
   logic [CoordWidth-1:0]        w_eff, h_eff;
   logic signed [CoordWidth-1:0] ox_s, oy_s, rs, req_x_s, req_y_s;
   logic signed [CoordWidth-1:0] lim_a, lim_b, lim_c, lim_d, lim_ab, lim_cd, lim_max;
   logic signed [CoordWidth-1:0] dx, dy, cx, cy;
   logic [CoordWidth-1:0]        dx_abs, dy_abs;
   logic [DistWidth-1:0]         cell_dist;
   logic                         in_grid;
   logic [ProdWidth-1:0]         cell_prod, org_prod;
   logic [AddrWidth-1:0]         cell_addr, org_addr;
   logic                         org_in_map;
   logic                         hit;
   logic                         ram_we;
   logic [AddrWidth-1:0]         ram_waddr;
   logic [0:0]                   ram_wdata;

   // Effective grid size, capped at the map size
   assign w_eff = ({2'b0, grid_w_ff} > MaxW) ? MaxW : {2'b0, grid_w_ff};
   assign h_eff = ({2'b0, grid_h_ff} > MaxH) ? MaxH : {2'b0, grid_h_ff};

   assign ox_s    = $signed({{ExtWidth{1'b0}}, ox_ff});
   assign oy_s    = $signed({{ExtWidth{1'b0}}, oy_ff});
   assign rs      = $signed({{(CoordWidth-RadWidth){1'b0}}, r_ff});
   assign req_x_s = $signed({{ExtWidth{1'b0}}, req_pos_x});
   assign req_y_s = $signed({{ExtWidth{1'b0}}, req_pos_y});

   // Ring limit: farthest grid edge seen from the origin
   assign lim_a   = req_x_s;
   assign lim_b   = $signed(w_eff) - req_x_s;
   assign lim_c   = req_y_s;
   assign lim_d   = $signed(h_eff) - req_y_s;
   assign lim_ab  = (lim_b > lim_a) ? lim_b : lim_a;
   assign lim_cd  = (lim_d > lim_c) ? lim_d : lim_c;
   assign lim_max = (lim_cd > lim_ab) ? lim_cd : lim_ab;

   // Cursor cell offsets and coordinates
   assign dx = phase_ff ? (side_ff ? -rs : rs) : off_ff;
   assign dy = phase_ff ? off_ff : (side_ff ? -rs : rs);
   assign cx = ox_s + dx;
   assign cy = oy_s + dy;
   assign dx_abs = dx[CoordWidth-1] ? CoordWidth'(-dx) : CoordWidth'(dx);
   assign dy_abs = dy[CoordWidth-1] ? CoordWidth'(-dy) : CoordWidth'(dy);
   assign cell_dist = DistWidth'(dx_abs + dy_abs);
   assign in_grid = !cx[CoordWidth-1] && (cx < $signed(w_eff))
                 && !cy[CoordWidth-1] && (cy < $signed(h_eff));

   // Map addresses: row times map width plus column
   assign cell_prod = ProdWidth'(cy) * ProdWidth'(MaxW) + ProdWidth'(cx);
   assign cell_addr = cell_prod[AddrWidth-1:0];
   assign org_prod  = ProdWidth'(oy_ff) * ProdWidth'(MaxW) + ProdWidth'(ox_ff);
   assign org_addr  = org_prod[AddrWidth-1:0];
   assign org_in_map = ({{ExtWidth{1'b0}}, ox_ff} < MaxW) && ({{ExtWidth{1'b0}}, oy_ff} < MaxH);

   // Strictly nearer marked cell replaces the best
   assign hit = probe_vld_ff && rd_data[0] && (!have_ff || probe_d_ff < best_d_ff);

   // Map write port select
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = 1'b0;
      priority if (cmd.clear_step) begin
         ram_we = 1'b1;
      end else if (cmd.write_cell) begin
         ram_we    = org_in_map;
         ram_waddr = org_addr;
         ram_wdata = mark_ff;
      end else if (cmd.claim) begin
         ram_we    = 1'b1;
         ram_waddr = best_addr_ff;
      end else begin
         ram_we = 1'b0;
      end
   end

   nmcs_ram #(
      .WIDTH(1),
      .DEPTH(Depth)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (cmd.step),
      .rd_addr(cell_addr),
      .rd_data(rd_data)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_w_ff <= GridSizeReset;
         grid_h_ff <= GridSizeReset;
      end else if (csr_valid) begin
         unique case (csr_addr)
            CsrGridWidth:  grid_w_ff <= csr_wdata;
            CsrGridHeight: grid_h_ff <= csr_wdata;
            default:       grid_w_ff <= grid_w_ff;
         endcase
      end
   end

   // Request capture, radius and clear counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         r_ff   <= '0;
         lim_ff <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.load) begin
            lim_ff <= lim_max[RadWidth-1:0];
            r_ff   <= RadWidth'(1);
         end else if (cmd.next_ring) begin
            r_ff <= r_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ox_ff   <= req_pos_x;
         oy_ff   <= req_pos_y;
         mark_ff <= req_cell_marked;
      end
   end

   // Ring cursor: rows by ascending x (top then bottom), then columns by descending y
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         side_ff  <= 1'b0;
         off_ff   <= '0;
      end else if (cmd.ring_start) begin
         phase_ff <= 1'b0;
         side_ff  <= 1'b0;
         off_ff   <= -rs;
      end else if (cmd.step) begin
         if (!side_ff) begin
            side_ff <= 1'b1;
         end else begin
            side_ff <= 1'b0;
            if (!phase_ff) begin
               if (off_ff == rs) begin
                  phase_ff <= 1'b1;
                  off_ff   <= rs - CoordWidth'(1);
               end else begin
                  off_ff <= off_ff + CoordWidth'(1);
               end
            end else begin
               off_ff <= off_ff - CoordWidth'(1);
            end
         end
      end
   end

   // Probe pipeline stage, aligned with the RAM read data
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_vld_ff <= 1'b0;
      end else begin
         probe_vld_ff <= cmd.step && in_grid;
      end
   end

   always_ff @(posedge clock) begin
      probe_x_ff    <= cx[PosWidth-1:0];
      probe_y_ff    <= cy[PosWidth-1:0];
      probe_d_ff    <= cell_dist;
      probe_addr_ff <= cell_addr;
   end

   // Best-cell tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (cmd.load) begin
         have_ff <= 1'b0;
      end else if (hit) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         best_x_ff    <= probe_x_ff;
         best_y_ff    <= probe_y_ff;
         best_d_ff    <= probe_d_ff;
         best_addr_ff <= probe_addr_ff;
      end
   end

   // Response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_found_ff <= 1'b0;
         rsp_x_ff     <= '0;
         rsp_y_ff     <= '0;
      end else begin
         rsp_valid_ff <= cmd.claim || cmd.respond_none;
         rsp_found_ff <= cmd.claim;
         rsp_x_ff     <= cmd.claim ? best_x_ff : '0;
         rsp_y_ff     <= cmd.claim ? best_y_ff : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_near_x = rsp_x_ff;
   assign rsp_near_y = rsp_y_ff;
   assign csr_ready  = 1'b1;

   // Status to the controller
   assign status.clear_last = (clr_ff == LastAddr);
   assign status.no_rings   = (lim_ff == '0);
   assign status.ring_last  = phase_ff && side_ff && (off_ff == CoordWidth'(1) - rs);
   assign status.last_ring  = (r_ff == lim_ff);
   assign status.have       = have_ff;

`ifndef SYNTHESIS
   // A result strobe never stays high on consecutive cycles
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   // A found result carries a strobe
   assert property (@(posedge clock) disable iff (reset) rsp_found_ff |-> rsp_valid_ff)
      else $error("found flag without result strobe");

   // Map writes never overlap a ring probe
   assert property (@(posedge clock) disable iff (reset) !(ram_we && cmd.step))
      else $error("map write during ring probe");
`endif

endmodule

FILE: hdl/nmcs_ctrl.sv
// Controller: sequences map clearing, cell writes and the ring-by-ring search.
module nmcs_ctrl import nmcs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            req_cmd,
   output logic            busy,
   output ctrl_cmd_type    cmd,
   input  ctrl_status_type status
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_START,
      ST_RING,
      ST_DRAIN,
      ST_CHECK
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_cmd == CmdSearch) ? ST_START : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_cell   = 1'b1;
            cmd.respond_none = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_START: begin
            if (status.no_rings) begin
               cmd.respond_none = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               cmd.ring_start = 1'b1;
               state_in       = ST_RING;
            end
         end
         ST_RING: begin
            cmd.step = 1'b1;
            if (status.ring_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last probe of the ring lands in the best-cell registers
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (status.have) begin
               cmd.claim = 1'b1;
               state_in  = ST_IDLE;
            end else if (status.last_ring) begin
               cmd.respond_none = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               cmd.next_ring = 1'b1;
               state_in      = ST_START;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef SYNTHESIS
   // An accepted transaction makes the unit busy on the next cycle
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // A claim only follows a ring that held a marked cell
   assert property (@(posedge clock) disable iff (reset) cmd.claim |-> status.have)
      else $error("claim without a found cell");
`endif

endmodule

FILE: test/tb_top.sv
// Testbench for the nearest marked cell search unit: directed and random traffic checked
// against a behavioral model.
module tb_top;
   import nmcs_pkg::*;

   // One response of the unit
   typedef struct packed {
      logic                found;
      logic [PosWidth-1:0] near_x;
      logic [PosWidth-1:0] near_y;
   } cell_result_type;

   typedef bit bool_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_cmd;
   logic [PosWidth-1:0]     req_pos_x;
   logic [PosWidth-1:0]     req_pos_y;
   logic                    req_cell_marked;
   logic                    rsp_valid;
   logic                    rsp_found;
   logic [PosWidth-1:0]     rsp_near_x;
   logic [PosWidth-1:0]     rsp_near_y;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CsrAddrWidth-1:0] csr_addr;
   logic [CfgWidth-1:0]     csr_wdata;

   // Model state: cell map, grid size registers, expected responses
   bit              marked_cells [MaxHeightDefault][MaxWidthDefault];
   int              grid_cols = 64;
   int              grid_rows = 64;
   cell_result_type expected_cells [$];
   int              mismatch_count = 0;
   int              send_idle_pct = 0;

   // Best candidate of the current ring walk
   bit           best_have;
   int           best_x;
   int           best_y;
   int           best_dist;

   nearest_marked_cell_search_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_cell_marked (req_cell_marked),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_near_x      (rsp_near_x),
      .rsp_near_y      (rsp_near_y),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog
   initial begin
      #96_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Grid size in use, clipped to the map size
   function automatic int eff_cols();
      return (grid_cols > MaxWidthDefault) ? MaxWidthDefault : grid_cols;
   endfunction

   function automatic int eff_rows();
      return (grid_rows > MaxHeightDefault) ? MaxHeightDefault : grid_rows;
   endfunction

   // Keep a marked in-grid cell if strictly nearer than the best so far
   function automatic void offer_cell(input int x, input int y, input int ox, input int oy,
                                      input int w, input int h);
      int d;
      if (x < 0 || x >= w || y < 0 || y >= h)
         return;
      if (!marked_cells[y][x])
         return;
      d = ((x > ox) ? x - ox : ox - x) + ((y > oy) ? y - oy : oy - y);
      if (!best_have || d < best_dist) begin
         best_have = 1'b1;
         best_x    = x;
         best_y    = y;
         best_dist = d;
      end
   endfunction

   // Ring walk from the origin; claims and returns the nearest marked cell
   function automatic cell_result_type search_and_claim(input int ox, input int oy);
      int              w;
      int              h;
      int              lim;
      cell_result_type res;
      w = eff_cols();
      h = eff_rows();
      lim = ox;
      if (w - ox > lim) lim = w - ox;
      if (oy > lim) lim = oy;
      if (h - oy > lim) lim = h - oy;
      best_have = 1'b0;
      best_x    = 0;
      best_y    = 0;
      best_dist = 0;
      for (int r = 1; r <= lim && !best_have; r++) begin
         // top and bottom rows, then right and left columns
         for (int x = ox - r; x <= ox + r; x++) begin
            offer_cell(x, oy + r, ox, oy, w, h);
            offer_cell(x, oy - r, ox, oy, w, h);
         end
         for (int y = oy + r; y >= oy - r; y--) begin
            offer_cell(ox + r, y, ox, oy, w, h);
            offer_cell(ox - r, y, ox, oy, w, h);
         end
      end
      res = '0;
      if (best_have) begin
         marked_cells[best_y][best_x] = 1'b0;
         res.found  = 1'b1;
         res.near_x = PosWidth'(best_x);
         res.near_y = PosWidth'(best_y);
      end
      return res;
   endfunction

   // Send one transaction, with an optional gap before it; start stays high on return
   task automatic send_item(input logic cmd, input int x, input int y, input logic mark);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_cmd         <= cmd;
      req_pos_x       <= PosWidth'(x);
      req_pos_y       <= PosWidth'(y);
      req_cell_marked <= mark;
      do @(posedge clock); while (busy);
      if (cmd == CmdWrite) begin
         marked_cells[y][x] = mark;
         expected_cells.push_back('0);
      end else begin
         expected_cells.push_back(search_and_claim(x, y));
      end
   endtask

   // Stop sending and wait for every outstanding response
   task automatic drain_responses();
      @(negedge clock);
      start <= 1'b0;
      while (expected_cells.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrAddrWidth-1:0] addr, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= CfgWidth'(value);
      do @(posedge clock); while (!csr_ready);
      if (addr == CsrGridWidth)
         grid_cols = value;
      else
         grid_rows = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_grid(input int w, input int h);
      write_csr(CsrGridWidth, w);
      write_csr(CsrGridHeight, h);
   endtask

   // Claims on the full layer: empty map, marked origin, ring order and ties
   task automatic test_claims();
      send_item(CmdSearch, 32, 32, 1'b0);
      send_item(CmdWrite, 0, 0, 1'b1);
      send_item(CmdWrite, 1, 1, 1'b1);
      send_item(CmdSearch, 0, 0, 1'b0);
      send_item(CmdSearch, 0, 0, 1'b0);
      send_item(CmdWrite, 63, 63, 1'b1);
      send_item(CmdSearch, 63, 62, 1'b1);
      // nearer cell in the ring wins, then a row tie goes to the lower column
      send_item(CmdWrite, 9, 12, 1'b1);
      send_item(CmdWrite, 11, 12, 1'b1);
      send_item(CmdWrite, 12, 10, 1'b1);
      send_item(CmdSearch, 10, 10, 1'b0);
      send_item(CmdSearch, 10, 10, 1'b0);
      send_item(CmdSearch, 10, 10, 1'b0);
      // cleared cell must not be found
      send_item(CmdWrite, 20, 20, 1'b1);
      send_item(CmdWrite, 20, 20, 1'b0);
      send_item(CmdSearch, 21, 21, 1'b0);
      // column tie goes to the right side
      send_item(CmdWrite, 32, 31, 1'b1);
      send_item(CmdWrite, 28, 31, 1'b1);
      send_item(CmdSearch, 30, 30, 1'b0);
      drain_responses();
   endtask

   // Empty, small and oversized grids; cells and origins outside the grid
   task automatic test_grid_edges();
      set_grid(0, 1);
      send_item(CmdSearch, 0, 0, 1'b0);
      drain_responses();
      set_grid(4, 4);
      send_item(CmdWrite, 5, 2, 1'b1);
      send_item(CmdSearch, 6, 2, 1'b0);
      drain_responses();
      set_grid(127, 127);
      send_item(CmdSearch, 6, 3, 1'b0);
      drain_responses();
      set_grid(1, 0);
      send_item(CmdSearch, 0, 0, 1'b0);
      drain_responses();
   endtask

   // Random writes and searches, mostly inside the grid
   task automatic test_random_phase(input int w, input int h, input int idle_pct,
                                    input int count);
      int       x;
      int       y;
      bool_type anywhere;
      drain_responses();
      set_grid(w, h);
      send_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         // sender holds off once until the unit has answered everything
         if (i == count / 2)
            drain_responses();
         if ($urandom_range(99) < 50) begin
            anywhere = ($urandom_range(99) < 15);
            x = anywhere ? $urandom_range(63) : $urandom_range(eff_cols() - 1);
            y = anywhere ? $urandom_range(63) : $urandom_range(eff_rows() - 1);
            send_item(CmdWrite, x, y, $urandom_range(99) < 80);
         end else begin
            anywhere = ($urandom_range(99) < 8);
            x = anywhere ? $urandom_range(63) : $urandom_range(eff_cols() - 1);
            y = anywhere ? $urandom_range(63) : $urandom_range(eff_rows() - 1);
            send_item(CmdSearch, x, y, 1'($urandom_range(1)));
         end
      end
      drain_responses();
   endtask

   // Response checker
   always @(posedge clock) begin
      cell_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_cells.size() == 0) begin
            $error("response with no transaction outstanding");
            mismatch_count++;
         end else begin
            want = expected_cells.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_found);
               mismatch_count++;
            end
            if (rsp_near_x !== want.near_x) begin
               $error("near_x: expected %0d, actual %0d", want.near_x, rsp_near_x);
               mismatch_count++;
            end
            if (rsp_near_y !== want.near_y) begin
               $error("near_y: expected %0d, actual %0d", want.near_y, rsp_near_y);
               mismatch_count++;
            end
         end
      end
   end

   // Test sequence
   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_cmd         = CmdWrite;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_cell_marked = 1'b0;
      csr_valid       = 1'b0;
      csr_addr        = CsrGridWidth;
      csr_wdata       = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 23;
      test_claims();
      test_grid_edges();
      test_random_phase(12, 9, 23, 39);
      test_random_phase(64, 64, 52, 39);
      test_random_phase(127, 20, 0, 39);

      drain_responses();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_cells.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
